### hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared types and constants for the ring-buffer deque, its controller and
// its datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int WORD_W = 32;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 11;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [WORD_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [WORD_W-1:0] push_value;
   } deq_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic [OCC_W-1:0]         occupancy;
   } deq_rsp_type;

   typedef struct packed {
      logic accept;
      logic execute;
      logic load;
   } deq_cmd_type;

   typedef struct packed {
      logic need_read;
   } deq_stat_type;

endpackage

### hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one beat through execute, optional memory fetch and response.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output deq_cmd_type  cmd,
   input  deq_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = stat.need_read ? ST_LOAD : ST_EMIT;
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = (state_ff == ST_EMIT);
   assign cmd.accept  = start && (state_ff == ST_IDLE);
   assign cmd.execute = (state_ff == ST_EXEC);
   assign cmd.load    = (state_ff == ST_LOAD);

endmodule

### hw/rtl/deq_datapath.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Ring memory, front and rear indices, item count and cached end values.
// ----------------------------------------------------------------------------
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH = 1024
)
(
   input  logic         clock,
   input  logic         reset,
   input  deq_cmd_type  cmd,
   output deq_stat_type stat,
   input  deq_req_type  req_payload,
   output deq_rsp_type  rsp_payload
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] ring_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   deq_req_type       req_ff;
   logic [IDX_W-1:0]  front_idx_ff, front_idx_in;
   logic [IDX_W-1:0]  rear_idx_ff, rear_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] front_val_ff, front_val_in;
   logic [WORD_W-1:0] rear_val_ff, rear_val_in;
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic [IDX_W-1:0]  front_inc, front_dec, rear_inc, rear_dec, rear_dec2;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic              wr_en;
   logic              need_read;
   logic              full, empty, last;

   assign front_inc = (front_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : front_idx_ff + IDX_W'(1);
   assign front_dec = (front_idx_ff == '0) ? IDX_W'(DEPTH - 1) : front_idx_ff - IDX_W'(1);
   assign rear_inc  = (rear_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : rear_idx_ff + IDX_W'(1);
   assign rear_dec  = (rear_idx_ff == '0) ? IDX_W'(DEPTH - 1) : rear_idx_ff - IDX_W'(1);
   assign rear_dec2 = (rear_dec == '0) ? IDX_W'(DEPTH - 1) : rear_dec - IDX_W'(1);

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign last  = (count_ff == CNT_W'(1));

   always_comb begin
      front_idx_in = front_idx_ff;
      rear_idx_in  = rear_idx_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      rear_val_in  = rear_val_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = front_dec;
      rd_addr      = front_inc;
      need_read    = 1'b0;
      if (cmd.execute) begin
         popped_in = NEG_ONE;
         status_in = STATUS_OK;
         case (req_ff.mode)
            MODE_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = front_dec;
                  front_idx_in = front_dec;
                  count_in     = count_ff + CNT_W'(1);
                  front_val_in = req_ff.push_value;
                  if (empty) begin
                     rear_val_in = req_ff.push_value;
                  end
               end
            end
            MODE_PUSH_REAR: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = rear_idx_ff;
                  rear_idx_in = rear_inc;
                  count_in    = count_ff + CNT_W'(1);
                  rear_val_in = req_ff.push_value;
                  if (empty) begin
                     front_val_in = req_ff.push_value;
                  end
               end
            end
            MODE_POP_FRONT: begin
               if (empty) begin
                  status_in    = STATUS_EMPTY;
                  front_val_in = NEG_ONE;
                  rear_val_in  = NEG_ONE;
               end else begin
                  popped_in    = front_val_ff;
                  front_idx_in = front_inc;
                  count_in     = count_ff - CNT_W'(1);
                  rd_addr      = front_inc;
                  if (last) begin
                     front_val_in = NEG_ONE;
                     rear_val_in  = NEG_ONE;
                  end else begin
                     need_read = 1'b1;
                  end
               end
            end
            default: begin
               if (empty) begin
                  status_in    = STATUS_EMPTY;
                  front_val_in = NEG_ONE;
                  rear_val_in  = NEG_ONE;
               end else begin
                  popped_in   = rear_val_ff;
                  rear_idx_in = rear_dec;
                  count_in    = count_ff - CNT_W'(1);
                  rd_addr     = rear_dec2;
                  if (last) begin
                     front_val_in = NEG_ONE;
                     rear_val_in  = NEG_ONE;
                  end else begin
                     need_read = 1'b1;
                  end
               end
            end
         endcase
      end else if (cmd.load) begin
         if (req_ff.mode == MODE_POP_FRONT) begin
            front_val_in = rd_data_ff;
         end else begin
            rear_val_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= req_ff.push_value;
      end
      if (cmd.execute) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
      front_val_ff <= front_val_in;
      rear_val_ff  <= rear_val_in;
      popped_ff    <= popped_in;
      status_ff    <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_idx_ff <= '0;
         rear_idx_ff  <= '0;
         count_ff     <= '0;
      end else begin
         front_idx_ff <= front_idx_in;
         rear_idx_ff  <= rear_idx_in;
         count_ff     <= count_in;
      end
   end

   assign stat.need_read = need_read;

   assign rsp_payload.popped_value = popped_ff;
   assign rsp_payload.status       = status_ff;
   assign rsp_payload.front_value  = front_val_ff;
   assign rsp_payload.rear_value   = rear_val_ff;
   assign rsp_payload.occupancy    = OCC_W'(count_ff);

endmodule

### hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Each beat steps through the execute and emit states, the latter giving the
// result strobe; a pop that leaves items behind also passes the load state.
// A new beat is taken only in idle, paced by the single read port of the
// ring memory and the controller sequence. The receiver cannot stall.
// Reset clears indices and count; the ring memory is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  deq_req_type req_payload,
   output logic        rsp_strobe,
   output deq_rsp_type rsp_payload
);

   deq_cmd_type  cmd;
   deq_stat_type stat;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted beat did not raise busy.");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Response strobe held for more than one cycle.");

   a_fail_pop_value : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status != STATUS_OK) |->
         (rsp_payload.popped_value == NEG_ONE))
      else $error("Failed operation returned a popped value.");

   a_empty_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.occupancy == '0) |->
         (rsp_payload.front_value == NEG_ONE) && (rsp_payload.rear_value == NEG_ONE))
      else $error("Empty deque reported end values.");
`endif

endmodule
